>>> rtl/tcw_pkg.sv
package tcw_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TOP   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [15:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0]  ATTR_RESET = 8'h07;

   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_BEL = 8'h07;
   localparam logic [7:0] CHR_BS  = 8'h08;
   localparam logic [7:0] CHR_HT  = 8'h09;
   localparam logic [7:0] CHR_LF  = 8'h0A;
   localparam logic [7:0] CHR_VT  = 8'h0B;
   localparam logic [7:0] CHR_FF  = 8'h0C;
   localparam logic [7:0] CHR_CR  = 8'h0D;
   localparam logic [7:0] CHR_DEL = 8'h7F;

   typedef struct packed {
      op_type      op;
      logic [7:0]  byte_in;
      logic [11:0] cell_index;
      logic        end_of_write;
   } req_type;

   typedef struct packed {
      logic [11:0] cursor_reg;
      logic [11:0] start_reg;
      logic [15:0] cell_data;
   } result_type;

endpackage

>>> rtl/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; #(
   parameter int COLUMNS      = 80,
   parameter int VISIBLE_ROWS = 25,
   parameter int STORED_ROWS  = 50,
   localparam int TOTAL = COLUMNS * STORED_ROWS,
   localparam int AW    = $clog2(TOTAL)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req,
   input  logic [7:0]    char_attr,
   output logic          res_valid,
   input  logic          res_ready,
   output result_type    res,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [15:0]   wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic [15:0]   rd_data
);

   localparam int PW   = $clog2(TOTAL + 1);
   localparam int CLW  = $clog2(COLUMNS);
   localparam int SW   = $clog2(TOTAL + COLUMNS * VISIBLE_ROWS + 1);
   localparam int OXW  = (PW > 12) ? PW : 12;
   localparam int IXW  = (AW > 12) ? AW : 12;

   typedef enum logic [2:0] {
      S_SWEEP, S_IDLE, S_SHIFT, S_BLANK, S_SNAP, S_READ, S_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [PW-1:0]  cursor_ff, cursor_in;
   logic [CLW-1:0] column_ff, column_in;
   logic [PW-1:0]  view_ff, view_in;
   logic [PW-1:0]  pub_ff, pub_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           eow_ff, eow_in;
   logic           clr_op_ff, clr_op_in;
   logic [15:0]    data_ff, data_in;

   logic [PW-1:0]  cur_inc, cur_dec, nl_pos;
   logic [SW-1:0]  cur_sw, view_lim, back;
   logic [IXW-1:0] idx_ext;
   logic [OXW-1:0] pub_out, view_out;
   logic [PW-1:0]  pub_next;

   assign cur_inc  = cursor_ff + PW'(1);
   assign cur_dec  = cursor_ff - PW'(1);
   assign nl_pos   = cursor_ff + PW'(COLUMNS) - PW'(column_ff);
   assign cur_sw   = SW'(cursor_ff);
   assign view_lim = SW'(view_ff) + SW'(COLUMNS * VISIBLE_ROWS);
   assign back     = SW'(column_ff) + SW'(COLUMNS * (VISIBLE_ROWS - 1));
   assign idx_ext  = IXW'(req.cell_index);
   assign pub_next = eow_ff ? cursor_ff : pub_ff;
   assign pub_out  = OXW'(pub_next);
   assign view_out = OXW'(view_ff);

   assign req_ready     = (state_ff == S_IDLE);
   assign res_valid     = (state_ff == S_DONE);
   assign res.cursor_reg = pub_out[11:0];
   assign res.start_reg  = view_out[11:0];
   assign res.cell_data  = data_ff;

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      column_in = column_ff;
      view_in   = view_ff;
      pub_in    = pub_ff;
      idx_in    = idx_ff;
      eow_in    = eow_ff;
      clr_op_in = clr_op_ff;
      data_in   = data_ff;
      wr_en     = 1'b0;
      wr_addr   = cursor_ff[AW-1:0];
      wr_data   = BLANK_CELL;
      rd_en     = 1'b0;
      rd_addr   = idx_ff + AW'(COLUMNS);
      unique case (state_ff)
         S_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == AW'(TOTAL - 1)) begin
               idx_in    = '0;
               clr_op_in = 1'b0;
               state_in  = clr_op_ff ? S_DONE : S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               eow_in  = (req.op == OP_WRITE) && req.end_of_write;
               data_in = '0;
               idx_in  = '0;
               unique case (req.op)
                  OP_WRITE: begin
                     unique case (req.byte_in)
                        CHR_NUL, CHR_BEL, CHR_HT, CHR_VT: begin
                           state_in = S_DONE;
                        end
                        CHR_BS: begin
                           if (column_ff != '0) begin
                              cursor_in = cur_dec;
                              column_in = column_ff - CLW'(1);
                              wr_en     = 1'b1;
                              wr_addr   = cur_dec[AW-1:0];
                           end
                           state_in = S_DONE;
                        end
                        CHR_DEL: begin
                           wr_en    = 1'b1;
                           state_in = S_DONE;
                        end
                        CHR_LF, CHR_CR, CHR_FF: begin
                           cursor_in = nl_pos;
                           column_in = '0;
                           state_in  = (nl_pos >= PW'(TOTAL)) ? S_SHIFT : S_SNAP;
                        end
                        default: begin
                           wr_en     = 1'b1;
                           wr_data   = {char_attr, req.byte_in};
                           cursor_in = cur_inc;
                           if (column_ff == CLW'(COLUMNS - 1)) begin
                              column_in = '0;
                              state_in  = (cur_inc >= PW'(TOTAL)) ? S_SHIFT : S_SNAP;
                           end else begin
                              column_in = column_ff + CLW'(1);
                              state_in  = S_DONE;
                           end
                        end
                     endcase
                  end
                  OP_CLEAR: begin
                     cursor_in = '0;
                     column_in = '0;
                     view_in   = '0;
                     pub_in    = '0;
                     clr_op_in = 1'b1;
                     state_in  = S_SWEEP;
                  end
                  OP_TOP: begin
                     view_in  = '0;
                     state_in = S_DONE;
                  end
                  OP_READ: begin
                     if (32'(req.cell_index) < TOTAL) begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_ext[AW-1:0];
                        state_in = S_READ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_SHIFT: begin
            rd_en   = (idx_ff != AW'(TOTAL - COLUMNS));
            wr_en   = (idx_ff != '0);
            wr_addr = idx_ff - AW'(1);
            wr_data = rd_data;
            if (idx_ff == AW'(TOTAL - COLUMNS)) begin
               cursor_in = cursor_ff - PW'(COLUMNS);
               state_in  = S_BLANK;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == AW'(TOTAL - 1)) begin
               idx_in   = '0;
               state_in = S_SNAP;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_SNAP: begin
            if (cur_sw >= view_lim) begin
               view_in = (cur_sw >= back) ? PW'(cur_sw - back) : '0;
            end
            state_in = S_DONE;
         end
         S_READ: begin
            data_in  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               pub_in   = pub_next;
               eow_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SWEEP;
         cursor_ff <= '0;
         column_ff <= '0;
         view_ff   <= '0;
         pub_ff    <= '0;
         idx_ff    <= '0;
         eow_ff    <= 1'b0;
         clr_op_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         column_ff <= column_in;
         view_ff   <= view_in;
         pub_ff    <= pub_in;
         idx_ff    <= idx_in;
         eow_ff    <= eow_in;
         clr_op_ff <= clr_op_in;
      end
      data_ff <= data_in;
   end

endmodule

>>> rtl/text_console_writer.sv
// Channel  | Ports                          | Contents
// request  | req_tvalid/tready/tdata/tuser/ | tdata: byte_in, cell_index; tuser: op;
//          | tlast                          | tlast: end_of_write
// response | rsp_tvalid/tready/tdata        | tdata: cursor_reg, start_reg, cell_data
// csr      | csr_wr_en/csr_wr_data          | char_attr
//
// Character without a wrap, control byte, DEL, BS, scroll to top: idle, then done; read: idle,
// read state, done. A character that wraps the line or a line break: idle, snap state, done.
// Store overflow: adds a row shift and a blank pass through one RAM port before the snap state.
// Clear: a sweep over all COLUMNS*STORED_ROWS cells, then done; after reset a clearing pass
// over all COLUMNS*STORED_ROWS cells runs with req_tready low.
// A finished response waits in the output register while the next request is taken.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS      = 80,
   parameter int VISIBLE_ROWS = 25,
   parameter int STORED_ROWS  = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_in[7:0], cell_index[19:8], zero pad
   input  logic [1:0]  req_tuser,   // op
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cursor_reg[11:0], start_reg[23:12], cell_data[39:24]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int TOTAL = COLUMNS * STORED_ROWS;
   localparam int AW    = $clog2(TOTAL);

   logic [7:0]  attr_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   req_type     req;
   result_type  res;
   logic        res_valid;
   logic        res_ready;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;

   assign req.op           = op_type'(req_tuser);
   assign req.byte_in      = req_tdata[7:0];
   assign req.cell_index   = req_tdata[19:8];
   assign req.end_of_write = req_tlast;

   assign res_ready  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.cell_data, rsp_ff.start_reg, rsp_ff.cursor_reg};

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   tcw_ctrl #(
      .COLUMNS      (COLUMNS),
      .VISIBLE_ROWS (VISIBLE_ROWS),
      .STORED_ROWS  (STORED_ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .char_attr (attr_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (TOTAL)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

>>> sim/tcw_checker.sv
module tcw_checker import tcw_pkg::*; #(
   parameter int COLUMNS      = 80,
   parameter int VISIBLE_ROWS = 25,
   parameter int STORED_ROWS  = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_in[7:0], cell_index[19:8], zero pad
   input  logic [1:0]  req_tuser,   // op
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // cursor_reg[11:0], start_reg[23:12], cell_data[39:24]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          mismatch_count,
   output int          pending,
   output int          rows_shifted,
   output int          view_moves
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL = COLUMNS * STORED_ROWS;

   logic [15:0] cells [0:TOTAL-1];
   int          cur_pos;
   int          cur_col;
   int          view_base;
   int          shown_cursor;
   logic [7:0]  attr;

   result_type  expected_status [$];
   result_type  want;
   result_type  predicted;
   logic [11:0] got_cursor;
   logic [11:0] got_start;
   logic [15:0] got_cell;
   int          responses = 0;

   initial begin
      mismatch_count = 0;
      pending        = 0;
      rows_shifted   = 0;
      view_moves     = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 30)
         $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void wipe_console();
      int i;
      for (i = 0; i < TOTAL; i++)
         cells[i] = BLANK_CELL;
      cur_pos      = 0;
      cur_col      = 0;
      view_base    = 0;
      shown_cursor = 0;
   endfunction

   function automatic void shift_rows_up();
      int i;
      if (cur_pos >= TOTAL) begin
         for (i = 0; i + COLUMNS < TOTAL; i++)
            cells[i] = cells[i + COLUMNS];
         cur_pos -= COLUMNS;
         for (i = TOTAL - COLUMNS; i < TOTAL; i++)
            cells[i] = BLANK_CELL;
         rows_shifted++;
      end
   endfunction

   function automatic void follow_cursor();
      int back;
      if (cur_pos >= view_base + COLUMNS * VISIBLE_ROWS) begin
         back = cur_col + COLUMNS * (VISIBLE_ROWS - 1);
         view_base = (cur_pos >= back) ? cur_pos - back : 0;
         view_moves++;
      end
   endfunction

   function automatic void apply_byte(input logic [7:0] b);
      case (b)
         CHR_NUL, CHR_BEL, CHR_HT, CHR_VT: begin
         end
         CHR_BS: begin
            if (cur_col > 0 && cur_pos > 0) begin
               cur_col--;
               cur_pos--;
               cells[cur_pos % TOTAL] = BLANK_CELL;
            end
         end
         CHR_DEL: begin
            cells[cur_pos % TOTAL] = BLANK_CELL;
         end
         CHR_LF, CHR_CR, CHR_FF: begin
            cur_pos = cur_pos + COLUMNS - cur_col;
            cur_col = 0;
            shift_rows_up();
            follow_cursor();
         end
         default: begin
            cells[cur_pos % TOTAL] = {attr, b};
            cur_pos++;
            cur_col++;
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               shift_rows_up();
               follow_cursor();
            end
         end
      endcase
   endfunction

   function automatic result_type next_status(input op_type op, input logic [7:0] b,
                                              input logic [11:0] idx, input logic last);
      result_type r;
      logic [15:0] data;
      data = 16'h0000;
      case (op)
         OP_WRITE: begin
            apply_byte(b);
            if (last)
               shown_cursor = cur_pos;
         end
         OP_CLEAR: wipe_console();
         OP_TOP:   view_base = 0;
         default: begin
            if (idx < TOTAL)
               data = cells[idx];
         end
      endcase
      r.cursor_reg = shown_cursor[11:0];
      r.start_reg  = view_base[11:0];
      r.cell_data  = data;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wipe_console();
         attr = ATTR_RESET;
         expected_status.delete();
      end else begin
         if (csr_wr_en)
            attr = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got_cursor = rsp_tdata[11:0];
            got_start  = rsp_tdata[23:12];
            got_cell   = rsp_tdata[39:24];
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no request waiting",
                                         responses));
            end else begin
               want = expected_status.pop_front();
               if (got_cursor !== want.cursor_reg)
                  report_mismatch($sformatf("response %0d cursor_reg: got %h, want %h",
                                            responses, got_cursor, want.cursor_reg));
               if (got_start !== want.start_reg)
                  report_mismatch($sformatf("response %0d start_reg: got %h, want %h",
                                            responses, got_start, want.start_reg));
               if (got_cell !== want.cell_data)
                  report_mismatch($sformatf("response %0d cell_data: got %h, want %h",
                                            responses, got_cell, want.cell_data));
            end
            responses++;
         end
         if (req_tvalid && req_tready) begin
            predicted = next_status(op_type'(req_tuser), req_tdata[7:0], req_tdata[19:8],
                                    req_tlast);
            expected_status.push_back(predicted);
         end
      end
      pending <= expected_status.size();
   end

endmodule

>>> sim/text_console_writer_test.sv
module text_console_writer_test import tcw_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS      = 80;
   localparam int VISIBLE_ROWS = 25;
   localparam int STORED_ROWS  = 50;
   localparam int RANDOM_ITEMS = 1150;
   localparam int PHASES       = 8;
   localparam int LONG_GAP     = 30;
   localparam int LONG_STALL   = 60;
   localparam int CYCLE_LIMIT  =
      (RANDOM_ITEMS + 250) * (COLUMNS * STORED_ROWS + 8 + LONG_GAP + LONG_STALL) * 3
      + 2 * COLUMNS * STORED_ROWS;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // byte_in[7:0], cell_index[19:8], zero pad
   logic [1:0]  req_tuser   = '0;   // op
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;          // cursor_reg[11:0], start_reg[23:12], cell_data[39:24]
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   int   mismatch_count;
   int   pending;
   int   rows_shifted;
   int   view_moves;

   logic steady     = 1'b0;
   int   ready_hold = 0;
   int   cycles     = 0;
   int   sent       = 0;
   int   reads      = 0;
   int   clears     = 0;
   int   tops       = 0;
   int   attr_writes = 0;
   int   phase;
   int   phase_end;

   always #1 clock = ~clock;

   text_console_writer #(
      .COLUMNS      (COLUMNS),
      .VISIBLE_ROWS (VISIBLE_ROWS),
      .STORED_ROWS  (STORED_ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tcw_checker #(
      .COLUMNS      (COLUMNS),
      .VISIBLE_ROWS (VISIBLE_ROWS),
      .STORED_ROWS  (STORED_ROWS)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending        (pending),
      .rows_shifted   (rows_shifted),
      .view_moves     (view_moves)
   );

   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady || $urandom_range(0, 2) != 0) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, LONG_STALL)
                                                   : $urandom_range(0, 2);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, LONG_GAP);
   endfunction

   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 99) < 85)
         return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] line_break();
      case ($urandom_range(0, 2))
         0:       return CHR_LF;
         1:       return CHR_CR;
         default: return CHR_FF;
      endcase
   endfunction

   function automatic logic [7:0] edit_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return CHR_BS;
         3, 4:    return CHR_DEL;
         5:       return CHR_NUL;
         6:       return CHR_BEL;
         7:       return CHR_HT;
         8:       return CHR_VT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [11:0] cell_pick();
      case ($urandom_range(0, 4))
         0, 1:    return 12'($urandom_range(0, COLUMNS * STORED_ROWS - 1));
         2:       return 12'($urandom_range(COLUMNS * (STORED_ROWS - 1),
                                            COLUMNS * STORED_ROWS - 1));
         3:       return 12'($urandom_range(0, 2 * COLUMNS - 1));
         default: return 12'($urandom_range(COLUMNS * STORED_ROWS, 4095));
      endcase
   endfunction

   task automatic send_request(input op_type op, input logic [7:0] code,
                               input logic [11:0] idx, input logic last);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'h0, idx, code};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (op == OP_READ)
         reads++;
      if (op == OP_CLEAR)
         clears++;
      if (op == OP_TOP)
         tops++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_attr(input logic [7:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      attr_writes++;
   endtask

   task automatic run_sequence();
      int         kind;
      int         len;
      int         i;
      logic       nl;
      logic       last;
      kind = $urandom_range(0, 99);
      steady <= ($urandom_range(0, 7) == 0);
      if (kind < 45) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
         nl  = 1'($urandom_range(0, 1));
         for (i = 0; i < len; i++) begin
            last = (i == len - 1 && !nl) || ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 19) == 0)
               send_request(OP_WRITE, edit_byte(), 12'($urandom_range(0, 4095)), last);
            else
               send_request(OP_WRITE, text_byte(), 12'($urandom_range(0, 4095)), last);
         end
         if (nl)
            send_request(OP_WRITE, line_break(), 12'($urandom_range(0, 4095)), 1'b1);
      end else if (kind < 60) begin
         len = $urandom_range(1, 12);
         for (i = 0; i < len; i++)
            send_request(OP_WRITE, line_break(), 12'($urandom_range(0, 4095)),
                         (i == len - 1) || $urandom_range(0, 1));
      end else if (kind < 75) begin
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++)
            send_request(OP_WRITE, edit_byte(), 12'($urandom_range(0, 4095)),
                         1'($urandom_range(0, 1)));
      end else if (kind < 90) begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++)
            send_request(OP_READ, 8'($urandom_range(0, 255)), cell_pick(),
                         1'($urandom_range(0, 1)));
      end else if (kind < 97) begin
         send_request(OP_TOP, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                      1'($urandom_range(0, 1)));
      end else begin
         send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                      1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_READ,  8'h00,   12'd0,    1'b0);
      send_request(OP_READ,  8'hFF,   12'd3999, 1'b1);
      send_request(OP_READ,  8'h00,   12'd4000, 1'b0);
      send_request(OP_READ,  8'h00,   12'hFFF,  1'b0);
      send_request(OP_WRITE, 8'h41,   12'hFFF,  1'b0);
      send_request(OP_WRITE, 8'h80,   12'd0,    1'b0);
      send_request(OP_WRITE, 8'hFF,   12'd0,    1'b0);
      send_request(OP_WRITE, 8'h20,   12'd0,    1'b1);
      send_request(OP_WRITE, CHR_BS,  12'd0,    1'b0);
      send_request(OP_WRITE, 8'h42,   12'd0,    1'b0);
      send_request(OP_WRITE, CHR_DEL, 12'd0,    1'b1);
      send_request(OP_WRITE, CHR_NUL, 12'd0,    1'b0);
      send_request(OP_WRITE, CHR_BEL, 12'd0,    1'b0);
      send_request(OP_WRITE, CHR_HT,  12'd0,    1'b0);
      send_request(OP_WRITE, CHR_VT,  12'd0,    1'b1);
      send_request(OP_WRITE, CHR_LF,  12'd0,    1'b0);
      send_request(OP_WRITE, CHR_BS,  12'd0,    1'b1);
      send_request(OP_WRITE, CHR_CR,  12'd0,    1'b0);
      send_request(OP_WRITE, CHR_FF,  12'd0,    1'b1);
      send_request(OP_READ,  8'h00,   12'd1,    1'b1);
      send_request(OP_READ,  8'h00,   12'd2,    1'b0);
      send_request(OP_TOP,   8'h00,   12'd0,    1'b1);
      send_request(OP_CLEAR, 8'h00,   12'd0,    1'b1);
      send_request(OP_READ,  8'h00,   12'd0,    1'b0);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:          set_attr(8'h00);
            1:          set_attr(8'hFF);
            PHASES - 1: set_attr(ATTR_RESET);
            default:    set_attr(8'($urandom_range(0, 255)));
         endcase
         phase_end = sent + RANDOM_ITEMS / PHASES;
         while (sent < phase_end)
            run_sequence();
      end

      steady <= 1'b0;
      wait_for_results();
      repeat (COLUMNS * STORED_ROWS + 16) @(posedge clock);

      $display("Sent %0d requests: %0d reads, %0d clears, %0d scrolls to top, %0d attr writes",
               sent, reads, clears, tops, attr_writes);
      $display("Store overflows: %0d, view moves: %0d", rows_shifted, view_moves);
      if (mismatch_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> text_console_writer.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
sim/tcw_checker.sv
sim/text_console_writer_test.sv
